/* hdl/sled_pkg.sv */
// shared types, codes and constants of the status led blink and code flasher
// no dependencies; imported by every module of the block
package sled_pkg;

  localparam int MAX_DIGITS_DEF  = 5;
  localparam int PERIOD_BITS_DEF = 13;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int HALF_W          = 13;

  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_START    = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_SEVERITY = 3'd3;
  localparam logic [2:0] CMD_READOUT  = 3'd4;

  localparam logic [2:0] SEV_ON       = 3'd0;
  localparam logic [2:0] SEV_STARTING = 3'd1;
  localparam logic [2:0] SEV_NORMAL   = 3'd2;
  localparam logic [2:0] SEV_CONFIG   = 3'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_ENABLED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS   = 2'd3;

  localparam logic [15:0]       PULSE_RESET = 16'd400;
  localparam logic [15:0]       GAP_RESET   = 16'd500;
  localparam logic [HALF_W-1:0] START_HALF  = 13'd2000;
  localparam logic [16:0]       DEC_RECIP   = 17'd52429;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  severity;
    logic [15:0] code_value;
  } item_t;

  typedef struct packed {
    logic pin_level;
    logic led_lit;
    logic running;
    logic readout_busy;
  } result_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ON,
    PH_OFF,
    PH_GAP
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CONV,
    S_DIGIT,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic conv_step;
    logic pos_load;
    logic digit_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic readout_item;
    logic need_digit;
    logic conv_done;
    logic conv_empty;
    logic digit_done;
  } dp_status_t;

  function automatic logic [HALF_W-1:0] sev_half(input logic [2:0] sev);
    logic [HALF_W-1:0] h;
    unique case (sev)
      SEV_ON:       h = 13'd5000;
      SEV_STARTING: h = 13'd2000;
      SEV_NORMAL:   h = 13'd1000;
      SEV_CONFIG:   h = 13'd500;
      default:      h = 13'd100;
    endcase
    return h;
  endfunction

endpackage

/* hdl/sled_dp.sv */
// datapath: config registers, blink timing, decimal conversion, digit sequencing
// depends on sled_pkg; driven by sled_ctrl through dp_cmd_t
module sled_dp import sled_pkg::*; #(
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  item_t                 item,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  output result_t               result
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic                   active_low;
  logic                   led_enabled;
  logic [15:0]            pulse_ticks;
  logic [15:0]            gap_ticks;

  item_t                  item_reg;
  logic                   lit;
  logic                   run_flag;
  logic [PERIOD_BITS-1:0] half_period;
  logic [PERIOD_BITS-1:0] elapsed_ticks;
  logic [3:0]             code_digits [MAX_DIGITS];
  logic [CNT_W-1:0]       digit_position;
  logic [3:0]             flashes_left;
  phase_t                 readout_phase;
  logic [15:0]            phase_timer;
  logic [15:0]            conv_val;
  logic [CNT_W-1:0]       conv_count;

  logic                   busy;
  logic [PERIOD_BITS-1:0] elapsed_inc;
  logic [15:0]            pulse_len;
  logic [15:0]            timer_dec;
  logic [3:0]             flashes_dec;
  logic                   pos_in;
  logic [3:0]             cur_digit;
  logic [32:0]            recip_prod;
  logic [15:0]            conv_q;
  logic [3:0]             conv_r;
  logic [IDX_W-1:0]       conv_widx;

  always_comb begin
    busy        = (readout_phase != PH_IDLE);
    elapsed_inc = (elapsed_ticks == '1) ? elapsed_ticks : elapsed_ticks + 1'b1;
    pulse_len   = (pulse_ticks == 16'd0) ? 16'd1 : pulse_ticks;
    timer_dec   = (phase_timer != 16'd0) ? phase_timer - 16'd1 : phase_timer;
    flashes_dec = (flashes_left != 4'd0) ? flashes_left - 4'd1 : flashes_left;
    pos_in      = (digit_position < CNT_W'(MAX_DIGITS));
    cur_digit   = code_digits[digit_position[IDX_W-1:0]];
    recip_prod  = 33'(conv_val) * 33'(DEC_RECIP);
    conv_q      = 16'(recip_prod[32:19]);
    conv_r      = 4'(conv_val - (conv_q << 3) - (conv_q << 1));
    conv_widx   = IDX_W'(MAX_DIGITS - 1) - IDX_W'(conv_count);
  end

  always_comb begin
    status.readout_item = (item_reg.cmd == CMD_READOUT);
    status.need_digit   = (item_reg.cmd == CMD_TICK) && busy && (timer_dec == 16'd0) &&
                          ((readout_phase == PH_GAP) ||
                           ((readout_phase == PH_OFF) && (flashes_dec == 4'd0) &&
                            (gap_ticks == 16'd0)));
    status.conv_done    = (conv_val == 16'd0) || (conv_count == CNT_W'(MAX_DIGITS));
    status.conv_empty   = (conv_count == '0);
    status.digit_done   = !pos_in || (cur_digit != 4'd0) || (gap_ticks != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_low  <= 1'b0;
      led_enabled <= 1'b1;
      pulse_ticks <= PULSE_RESET;
      gap_ticks   <= GAP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ACTIVE_LOW:  active_low  <= cfg_data[0];
        CFG_LED_ENABLED: led_enabled <= cfg_data[0];
        CFG_PULSE_TICKS: pulse_ticks <= cfg_data;
        CFG_GAP_TICKS:   gap_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_reg <= item;
    end
    if (cmd.out_load) begin
      result.pin_level    <= lit ^ active_low;
      result.led_lit      <= lit;
      result.running      <= run_flag;
      result.readout_busy <= busy;
    end
    if (cmd.conv_step) begin
      conv_val   <= conv_q;
      conv_count <= conv_count + 1'b1;
    end else if (cmd.exec && item_reg.cmd == CMD_READOUT) begin
      conv_val   <= item_reg.code_value;
      conv_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lit            <= 1'b0;
      run_flag       <= 1'b0;
      half_period    <= '0;
      elapsed_ticks  <= '0;
      digit_position <= '0;
      flashes_left   <= 4'd0;
      readout_phase  <= PH_IDLE;
      phase_timer    <= 16'd0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        code_digits[i] <= 4'd0;
      end
    end else if (cmd.exec) begin
      unique case (item_reg.cmd)
        CMD_TICK: begin
          elapsed_ticks <= elapsed_inc;
          if (busy) begin
            phase_timer <= timer_dec;
            if (timer_dec == 16'd0) begin
              unique case (readout_phase)
                PH_ON: begin
                  lit           <= 1'b0;
                  readout_phase <= PH_OFF;
                  phase_timer   <= pulse_len;
                end
                PH_OFF: begin
                  flashes_left <= flashes_dec;
                  if (flashes_dec != 4'd0) begin
                    lit           <= 1'b1;
                    readout_phase <= PH_ON;
                    phase_timer   <= pulse_len;
                  end else if (gap_ticks != 16'd0) begin
                    lit           <= 1'b0;
                    readout_phase <= PH_GAP;
                    phase_timer   <= gap_ticks;
                  end else begin
                    digit_position <= digit_position + 1'b1;
                  end
                end
                default: begin
                  digit_position <= digit_position + 1'b1;
                end
              endcase
            end
          end else if (run_flag) begin
            if (!led_enabled || half_period == '0) begin
              lit <= 1'b0;
            end else if (elapsed_inc > half_period) begin
              lit           <= ~lit;
              elapsed_ticks <= '0;
            end
          end
        end
        CMD_START: begin
          if (led_enabled) begin
            run_flag      <= 1'b1;
            half_period   <= PERIOD_BITS'(START_HALF);
            elapsed_ticks <= '0;
            if (!busy) begin
              lit <= 1'b1;
            end
          end else begin
            run_flag <= 1'b0;
          end
        end
        CMD_STOP: begin
          run_flag <= 1'b0;
        end
        CMD_SEVERITY: begin
          half_period   <= PERIOD_BITS'(sev_half(item_reg.severity));
          elapsed_ticks <= '0;
          if (!busy) begin
            lit <= 1'b1;
          end
        end
        CMD_READOUT: begin
          for (int i = 0; i < MAX_DIGITS; i++) begin
            code_digits[i] <= 4'd0;
          end
        end
        default: ;
      endcase
    end else if (cmd.conv_step) begin
      code_digits[conv_widx] <= conv_r;
    end else if (cmd.pos_load) begin
      digit_position <= CNT_W'(MAX_DIGITS) - conv_count;
    end else if (cmd.digit_step) begin
      flashes_left <= pos_in ? cur_digit : 4'd0;
      if (!pos_in) begin
        lit           <= 1'b0;
        readout_phase <= PH_IDLE;
        phase_timer   <= 16'd0;
      end else if (cur_digit != 4'd0) begin
        lit           <= 1'b1;
        readout_phase <= PH_ON;
        phase_timer   <= pulse_len;
      end else begin
        lit <= 1'b0;
        if (gap_ticks != 16'd0) begin
          readout_phase <= PH_GAP;
          phase_timer   <= gap_ticks;
        end else begin
          digit_position <= digit_position + 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/sled_ctrl.sv */
// controller: sequences accept, execute, conversion, digit steps and result
// depends on sled_pkg; commands sled_dp through dp_cmd_t
module sled_ctrl import sled_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  output logic       result_valid,
  input  logic       result_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic        out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.readout_item) begin
          state_next = S_CONV;
        end else if (status.need_digit) begin
          state_next = S_DIGIT;
        end else begin
          state_next = S_RESP;
        end
      end
      S_CONV: begin
        if (!status.conv_done) begin
          cmd.conv_step = 1'b1;
        end else if (status.conv_empty) begin
          state_next = S_RESP;
        end else begin
          cmd.pos_load = 1'b1;
          state_next   = S_DIGIT;
        end
      end
      S_DIGIT: begin
        cmd.digit_step = 1'b1;
        if (status.digit_done) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid || result_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    out_valid_next = cmd.out_load ? 1'b1 : (result_ready ? 1'b0 : out_valid);
    result_valid   = out_valid;
  end

endmodule

/* hdl/status_led_blink_and_code_flasher_unit.sv */
// status led blink and code flasher, top level: controller plus datapath
// depends on sled_pkg, sled_ctrl, sled_dp
// sequence: idle accepts an item, exec runs it, resp hands out the result; a tick that
//   ends a digit adds digit steps; a readout adds conversion steps of the
//   one-digit-per-cycle reciprocal divider, a position load and digit steps
// throughput: one item in flight; a new item is taken while the last result waits
// reset: synchronous, active high; config returns to defaults, led dark and stopped
module status_led_blink_and_code_flasher_unit import sled_pkg::*; #(
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign cfg_ready = 1'b1;

  sled_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (dp_status),
    .cmd          (dp_cmd)
  );

  sled_dp #(
    .MAX_DIGITS  (MAX_DIGITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (dp_cmd),
    .status    (dp_status),
    .result    (result)
  );

endmodule

/* hdl/sled_chk.sv */
// port-level checker for the status led blink and code flasher, with its bind
// depends on sled_pkg and status_led_blink_and_code_flasher_unit
module sled_chk import sled_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // a waiting result holds until its transfer
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // an accepted item closes the input right after its transfer
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input open right after a transfer");

  // a new result only comes out of a processing cycle
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result appeared without processing");

endmodule

bind status_led_blink_and_code_flasher_unit sled_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
